### design/rsts_pkg.sv
`default_nettype none

package rsts_pkg;

    typedef struct packed {
        logic               mode;
        logic [9:0]         entry_index;
        logic signed [31:0] data_value;
    } in_t;

    typedef struct packed {
        logic       found;
        logic [9:0] match_index;
    } out_t;

    localparam int STEP_W = 4;

    // microcode steps
    localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] S_INIT  = 4'd1;
    localparam logic [STEP_W-1:0] S_FIRST = 4'd2;
    localparam logic [STEP_W-1:0] S_TLOOP = 4'd3;
    localparam logic [STEP_W-1:0] S_TCMP  = 4'd4;
    localparam logic [STEP_W-1:0] S_TEND  = 4'd5;
    localparam logic [STEP_W-1:0] S_RANGE = 4'd6;
    localparam logic [STEP_W-1:0] S_SLOOP = 4'd7;
    localparam logic [STEP_W-1:0] S_SCMP  = 4'd8;
    localparam logic [STEP_W-1:0] S_DONE  = 4'd9;

    // read address source
    localparam logic [1:0] A_ZERO = 2'd0;
    localparam logic [1:0] A_MID  = 2'd1;
    localparam logic [1:0] A_LAST = 2'd2;

    // datapath operation
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_ACCEPT = 3'd1;
    localparam logic [2:0] OP_INIT   = 3'd2;
    localparam logic [2:0] OP_FIRST  = 3'd3;
    localparam logic [2:0] OP_TSTEP  = 3'd4;
    localparam logic [2:0] OP_TURN   = 3'd5;
    localparam logic [2:0] OP_RANGE  = 3'd6;
    localparam logic [2:0] OP_SSTEP  = 3'd7;

    // jump condition
    localparam logic [2:0] C_ALWAYS  = 3'd0;
    localparam logic [2:0] C_SEARCH  = 3'd1;
    localparam logic [2:0] C_EMPTY   = 3'd2;
    localparam logic [2:0] C_LT      = 3'd3;
    localparam logic [2:0] C_LE      = 3'd4;
    localparam logic [2:0] C_MATCH   = 3'd5;
    localparam logic [2:0] C_OUTFREE = 3'd6;

    typedef struct packed {
        logic [1:0]        asel;
        logic [2:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] jump_t;
        logic [STEP_W-1:0] jump_f;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{asel: A_ZERO, op: OP_NONE, cond: C_ALWAYS, jump_t: S_IDLE, jump_f: S_IDLE};
        case (step)
            S_IDLE:  c = '{asel: A_ZERO, op: OP_ACCEPT, cond: C_SEARCH,
                           jump_t: S_INIT,  jump_f: S_IDLE};
            S_INIT:  c = '{asel: A_ZERO, op: OP_INIT,   cond: C_EMPTY,
                           jump_t: S_DONE,  jump_f: S_FIRST};
            S_FIRST: c = '{asel: A_ZERO, op: OP_FIRST,  cond: C_ALWAYS,
                           jump_t: S_TLOOP, jump_f: S_TLOOP};
            S_TLOOP: c = '{asel: A_MID,  op: OP_NONE,   cond: C_LT,
                           jump_t: S_TCMP,  jump_f: S_TEND};
            S_TCMP:  c = '{asel: A_ZERO, op: OP_TSTEP,  cond: C_ALWAYS,
                           jump_t: S_TLOOP, jump_f: S_TLOOP};
            S_TEND:  c = '{asel: A_LAST, op: OP_TURN,   cond: C_ALWAYS,
                           jump_t: S_RANGE, jump_f: S_RANGE};
            S_RANGE: c = '{asel: A_ZERO, op: OP_RANGE,  cond: C_ALWAYS,
                           jump_t: S_SLOOP, jump_f: S_SLOOP};
            S_SLOOP: c = '{asel: A_MID,  op: OP_NONE,   cond: C_LE,
                           jump_t: S_SCMP,  jump_f: S_DONE};
            S_SCMP:  c = '{asel: A_ZERO, op: OP_SSTEP,  cond: C_MATCH,
                           jump_t: S_DONE,  jump_f: S_SLOOP};
            S_DONE:  c = '{asel: A_ZERO, op: OP_NONE,   cond: C_OUTFREE,
                           jump_t: S_IDLE,  jump_f: S_DONE};
            default: c = '{asel: A_ZERO, op: OP_NONE,   cond: C_ALWAYS,
                           jump_t: S_IDLE,  jump_f: S_IDLE};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/rsts_ram.sv
`default_nettype none

module rsts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/rotated_sorted_table_search.sv
`default_nettype none

// Search of a rotated ascending table of distinct signed 32-bit words. A load transaction
// (mode 0) writes one entry and gives no result; indexes at or above TABLE_DEPTH are
// dropped. A search transaction (mode 1) gives one result: a small microcode program first
// bisects for the rotation point (smallest entry), then bisects the sorted run that can hold
// the key. Every bisection step takes a read step and a compare step because the table RAM
// has a registered read. The turn search takes at most ceil(log2(n)) steps and the key search
// at most floor(log2(n)) + 1 probes; the next transaction is taken in the cycle after the
// result is loaded. An empty table goes from the init step straight to the last step. A
// result not yet taken holds the program in its last step and blocks the input. The user
// must write entries_in_use on the cfg channel only while the block is idle; the block
// itself does not enforce this. Values above TABLE_DEPTH act as TABLE_DEPTH. Entries below
// entries_in_use must have been loaded before a search.
module rotated_sorted_table_search
    import rsts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = CW + 1;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [10:0]        eiu_reg, eiu_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      n_reg, n_next;
    logic signed [PW-1:0] lo_reg, lo_next;
    logic signed [PW-1:0] hi_reg, hi_next;
    logic signed [31:0] first_reg, first_next;
    logic [CW-1:0]      turn_reg, turn_next;
    logic signed [31:0] vturn_reg, vturn_next;
    logic               res_found_reg, res_found_next;
    logic [9:0]         res_idx_reg, res_idx_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    ctrl_t              ctrl;
    logic               cond_true;
    logic               out_free;
    logic signed [PW:0] mid_sum;
    logic signed [PW-1:0] mid;
    logic [31:0]        mid_ext;
    logic [CW-1:0]      n_last;
    logic [31:0]        idx_ext;
    logic [31:0]        eiu_ext;
    logic               ram_we;
    logic [AW-1:0]      raddr;
    logic signed [31:0] rdata;

    assign ctrl     = ucode(step_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign mid_sum  = {lo_reg[PW-1], lo_reg} + {hi_reg[PW-1], hi_reg};
    assign mid      = mid_sum[PW:1];
    assign mid_ext  = 32'($unsigned(mid));
    assign n_last   = n_reg - CW'(1);
    assign idx_ext  = 32'(s_data.entry_index);
    assign eiu_ext  = 32'(eiu_reg);

    assign s_ready   = (ctrl.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign ram_we = s_ready && s_valid && !s_data.mode && (idx_ext < 32'(TABLE_DEPTH));

    always_comb begin
        case (ctrl.asel)
            A_MID:   raddr = mid[AW-1:0];
            A_LAST:  raddr = n_last[AW-1:0];
            default: raddr = '0;
        endcase
    end

    rsts_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (s_data.data_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        case (ctrl.cond)
            C_SEARCH:  cond_true = s_valid && s_data.mode;
            C_EMPTY:   cond_true = (n_reg == '0);
            C_LT:      cond_true = (lo_reg < hi_reg);
            C_LE:      cond_true = (lo_reg <= hi_reg);
            C_MATCH:   cond_true = (rdata == key_reg);
            C_OUTFREE: cond_true = out_free;
            default:   cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.jump_t : ctrl.jump_f;
    end

    always_comb begin
        eiu_next       = cfg_valid ? cfg_data : eiu_reg;
        key_next       = key_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        turn_next      = turn_reg;
        vturn_next     = vturn_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        case (ctrl.op)
            OP_ACCEPT: begin
                if (s_valid && s_data.mode) begin
                    key_next       = s_data.data_value;
                    n_next         = (eiu_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                  : CW'(eiu_reg);
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                end
            end
            OP_INIT: begin
                lo_next = '0;
                hi_next = $signed({1'b0, n_reg}) - PW'(1);
            end
            OP_FIRST: begin
                first_next = rdata;
            end
            OP_TSTEP: begin
                if (rdata >= first_reg) begin
                    lo_next = mid + PW'(1);
                end else begin
                    hi_next = mid;
                end
            end
            OP_TURN: begin
                if (rdata < first_reg) begin
                    turn_next  = lo_reg[CW-1:0];
                    vturn_next = rdata;
                end else begin
                    turn_next  = '0;
                    vturn_next = first_reg;
                end
            end
            OP_RANGE: begin
                if (key_reg >= vturn_reg && key_reg <= rdata) begin
                    lo_next = $signed({1'b0, turn_reg});
                    hi_next = $signed({1'b0, n_reg}) - PW'(1);
                end else begin
                    lo_next = '0;
                    hi_next = $signed({1'b0, turn_reg}) - PW'(1);
                end
            end
            OP_SSTEP: begin
                if (rdata == key_reg) begin
                    res_found_next = 1'b1;
                    res_idx_next   = mid_ext[9:0];
                end else if (key_reg < rdata) begin
                    hi_next = mid - PW'(1);
                end else begin
                    lo_next = mid + PW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // output register, loaded when the program leaves its last step
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (step_reg == S_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = '{found: res_found_reg, match_index: res_idx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= S_IDLE;
            eiu_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            eiu_reg     <= eiu_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        first_reg     <= first_next;
        turn_reg      <= turn_next;
        vturn_reg     <= vturn_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire

### tb/tb_rotated_sorted_table_search.sv
module tb_rotated_sorted_table_search;
    import rsts_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int TOTAL_ITEMS = 1950;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 80;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;

    // transactions waiting for the driver, and search answers still to come
    in_t  item_queue[$];
    out_t expected_hits[$];

    // predictor state
    int model_table[DEPTH];
    int model_len = 0;

    // table contents as the generator has planned them
    int gen_tab[DEPTH];
    int seq_buf[DEPTH];
    int items_made = 0;

    int errors       = 0;
    int cycle_count  = 0;
    int results_seen = 0;
    int hold_cnt     = 0;
    int holds_done   = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int rdy_mode     = 0;
    int rdy_left     = 0;
    logic rdy_pat;
    out_t want;

    rotated_sorted_table_search #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int find_turn(int n);
        int lo, hi, mid, first;
        lo = 0;
        hi = n - 1;
        first = model_table[0];
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_table[mid] >= first) lo = mid + 1;
            else hi = mid;
        end
        return (model_table[lo] < first) ? lo : 0;
    endfunction

    function automatic int bisect_run(int lo_in, int hi_in, int key);
        int lo, hi, mid;
        lo = lo_in;
        hi = hi_in;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_table[mid] == key) return mid;
            if (key < model_table[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic out_t lookup_key(int key);
        int n, turn, hit;
        out_t r;
        n = (model_len > DEPTH) ? DEPTH : model_len;
        hit = -1;
        if (n > 0) begin
            turn = find_turn(n);
            if (key >= model_table[turn] && key <= model_table[n-1])
                hit = bisect_run(turn, n - 1, key);
            else
                hit = bisect_run(0, turn - 1, key);
        end
        r.found = (hit >= 0);
        r.match_index = (hit >= 0) ? 10'(hit) : 10'd0;
        return r;
    endfunction

    function automatic void apply_item(in_t it);
        if (it.mode == MODE_LOAD)
            model_table[it.entry_index] = int'(it.data_value);
        else
            expected_hits.push_back(lookup_key(int'(it.data_value)));
    endfunction

    function automatic void push_load(int idx, int val);
        in_t it;
        it.mode = MODE_LOAD;
        it.entry_index = 10'(idx);
        it.data_value = val;
        gen_tab[idx] = val;
        item_queue.push_back(it);
        items_made++;
    endfunction

    function automatic void push_search(int key);
        in_t it;
        it.mode = MODE_SEARCH;
        it.entry_index = 10'($urandom_range(0, DEPTH - 1));
        it.data_value = key;
        item_queue.push_back(it);
        items_made++;
    endfunction

    // ascending distinct values, rotated, loaded in a wrapped order
    function automatic void load_rotated(int n);
        longint lim, step_max, slack, v;
        int r, k, i;
        lim = 64'd4294967295 / (n + 1);
        if (lim < 1) lim = 1;
        step_max = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                : $urandom_range(1, 32'(lim));
        slack = 64'd4294967295 - longint'(n) * step_max;
        v = -64'sd2147483648 + (longint'($urandom) % (slack + 1));
        for (int j = 0; j < n; j++) begin
            seq_buf[j] = int'(v);
            v = v + $urandom_range(1, 32'(step_max));
        end
        r = $urandom_range(0, n - 1);
        k = $urandom_range(0, n - 1);
        for (int j = 0; j < n; j++) begin
            i = (k + j) % n;
            push_load(i, seq_buf[(i + r) % n]);
        end
    endfunction

    // random contents with duplicates, not a rotated run
    function automatic void load_scrambled(int n);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 2) == 0)
                push_load(i, gen_tab[$urandom_range(0, i - 1)]);
            else
                push_load(i, $urandom);
        end
    endfunction

    function automatic int pick_key(int n);
        int i;
        if (n == 0) return $urandom;
        i = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return gen_tab[i];
            5:             return gen_tab[i] + 1;
            6:             return gen_tab[i] - 1;
            7, 8:          return $urandom;
            default:       return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic wait_idle();
        while (item_queue.size() != 0 || s_valid || expected_hits.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_len(input int len);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= 11'(len);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_len = len & 2047;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_item(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (item_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= item_queue.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: found %0d index %0d",
                                              m_data.found, m_data.match_index));
                end else begin
                    want = expected_hits.pop_front();
                    if (m_data.found !== want.found)
                        report_mismatch($sformatf("found: got %0d expected %0d",
                                                  m_data.found, want.found));
                    if (m_data.match_index !== want.match_index)
                        report_mismatch($sformatf("match_index: got %0d expected %0d",
                                                  m_data.match_index, want.match_index));
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(20, 200);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                0:       rdy_pat = 1'b1;
                1:       rdy_pat = ($urandom_range(0, 1) == 0);
                2:       rdy_pat = ($urandom_range(0, 3) == 0);
                default: rdy_pat = (cycle_count % 3 == 0);
            endcase
            m_ready <= rdy_pat && (hold_cnt == 0);
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (item_queue.size() > 2 &&
                     ((holds_done == 0 && results_seen >= 120) ||
                      (holds_done == 1 && results_seen >= 300))) begin
            hold_cnt   <= 400;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int n, n_eff, sel, searches;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table straight out of reset
        @(negedge aclk);
        push_search(0);
        push_search(32'h7fff_ffff);
        push_load(0, 10);
        push_load(1, 20);
        push_load(2, 32'h7fff_ffff);
        push_load(3, 32'h8000_0000);
        push_load(4, -5);
        push_load(5, 3);
        push_load(DEPTH - 1, -1);

        wait_idle();
        write_len(6);
        @(negedge aclk);
        for (int i = 0; i < 6; i++) push_search(gen_tab[i]);
        push_search(0);
        push_search(15);
        push_search(4);
        push_search(-6);

        // single entry
        wait_idle();
        write_len(1);
        @(negedge aclk);
        push_search(10);
        push_search(11);

        wait_idle();
        write_len(0);
        @(negedge aclk);
        push_search(10);

        // full table, then lengths past the table depth
        wait_idle();
        write_len(DEPTH);
        @(negedge aclk);
        load_rotated(DEPTH);
        for (int i = 0; i < 20; i++) push_search(pick_key(DEPTH));
        wait_idle();
        write_len(2047);
        @(negedge aclk);
        for (int i = 0; i < 10; i++) push_search(pick_key(DEPTH));
        wait_idle();
        write_len(1500);
        @(negedge aclk);
        for (int i = 0; i < 5; i++) push_search(pick_key(DEPTH));

        while (items_made < TOTAL_ITEMS) begin
            wait_idle();
            sel = $urandom_range(0, 19);
            if (sel == 0) n = 0;
            else if (sel == 1) n = $urandom_range(101, 200);
            else if (sel <= 3) n = $urandom_range(17, 100);
            else if (sel == 4) n = $urandom_range(DEPTH + 1, 2047);
            else n = $urandom_range(1, 16);
            n_eff = (n > DEPTH) ? DEPTH : n;
            write_len(n);
            @(negedge aclk);
            if (n > 0 && n <= DEPTH) begin
                if ($urandom_range(0, 4) == 0) load_scrambled(n);
                else load_rotated(n);
            end
            searches = (n == 0) ? 4 : $urandom_range(6, 20);
            for (int i = 0; i < searches; i++) begin
                if (n_eff < DEPTH && $urandom_range(0, 9) == 0)
                    push_load($urandom_range(n_eff, DEPTH - 1), $urandom);
                if (n_eff > 0 && $urandom_range(0, 29) == 0)
                    push_load($urandom_range(0, n_eff - 1), $urandom);
                push_search(pick_key(n_eff));
            end
        end

        while (item_queue.size() != 0 || s_valid) @(posedge aclk);
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
